// ===== rtl/xoshiro256pp_generator_unit_macros.svh =====
// Assertion macros shared by the generator RTL.
// Both sample on clk and are disabled while arst_n is low.
`ifndef XOSHIRO256PP_GENERATOR_UNIT_MACROS_SVH
`define XOSHIRO256PP_GENERATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XSR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/xsr_pkg.sv =====
package xsr_pkg;

	typedef logic [63:0] word_t;
	typedef word_t [3:0] words_t;

	localparam logic [1:0] KIND_NEXT = 2'd0;
	localparam logic [1:0] KIND_SEED = 2'd1;
	localparam logic [1:0] KIND_JUMP = 2'd2;

	localparam words_t DEFAULT_SEED = {
		64'hea9bfe26838f091d, 64'h0c60dc05b8f9266a,
		64'h8f51e36d13fa4f21, 64'h172373c35cc277fb
	};

	// Bit b of the jump polynomial is JUMP_POLY[b].
	localparam logic [255:0] JUMP_POLY = {
		64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
		64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
	};

	localparam logic [7:0] LAST_BIT = 8'hff;

	typedef enum logic {
		ST_IDLE,
		ST_JUMP
	} gen_state_t;

	typedef struct packed {
		logic       start;
		logic [1:0] kind;
		logic [15:0] jump_count;
	} core_ctrl_t;

	typedef struct packed {
		logic  busy;
		logic  done;
		word_t value;
	} core_stat_t;

endpackage

// ===== rtl/xsr_if.sv =====
interface xsr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] jump_count;

	modport source(output valid, output kind, output jump_count, input ready);
	modport sink(input valid, input kind, input jump_count, output ready);
endinterface

interface xsr_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

interface xsr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/xsr_step.sv =====
module xsr_step (
	input  xsr_pkg::words_t s,
	output xsr_pkg::words_t s_next,
	output xsr_pkg::word_t  rnd
);
	import xsr_pkg::*;

	word_t t;
	word_t x2;
	word_t x3;
	word_t y1;
	word_t y0;
	word_t sum;
	word_t sum_rot;

	assign t  = {s[1][46:0], 17'd0};
	assign x2 = s[2] ^ s[0];
	assign x3 = s[3] ^ s[1];
	assign y1 = s[1] ^ x2;
	assign y0 = s[0] ^ x3;

	assign s_next[0] = y0;
	assign s_next[1] = y1;
	assign s_next[2] = x2 ^ t;
	assign s_next[3] = {x3[18:0], x3[63:19]};

	assign sum     = s[0] + s[3];
	assign sum_rot = {sum[40:0], sum[63:41]};
	assign rnd     = sum_rot + s[0];
endmodule

// ===== rtl/xsr_core.sv =====
module xsr_core (
	input  logic               clk,
	input  logic               arst_n,
	input  xsr_pkg::core_ctrl_t ctrl,
	input  xsr_pkg::words_t    seed,
	output xsr_pkg::core_stat_t stat
);
	import xsr_pkg::*;

	gen_state_t  state_q;
	gen_state_t  state_d;
	words_t      gs_q;
	words_t      acc_q;
	logic [7:0]  bit_q;
	logic [15:0] left_q;

	words_t      step_next;
	word_t       rnd;
	logic        poly_bit;
	logic        last_bit;
	logic        jump_start;
	logic        seed_zero;

	xsr_step u_step (
		.s      (gs_q),
		.s_next (step_next),
		.rnd    (rnd)
	);

	assign poly_bit   = JUMP_POLY[bit_q];
	assign seed_zero  = (seed == '0);
	assign jump_start = ctrl.start && (ctrl.kind == KIND_JUMP) && (ctrl.jump_count != 16'd0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (jump_start) begin
					state_d = ST_JUMP;
				end
			end
			ST_JUMP: begin
				if (bit_q == LAST_BIT && left_q == 16'd1) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		stat     = '0;
		last_bit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				stat.done = ctrl.start && !jump_start;
				if (ctrl.start && ctrl.kind == KIND_NEXT) begin
					stat.value = rnd;
				end
			end
			ST_JUMP: begin
				stat.busy = 1'b1;
				last_bit  = (bit_q == LAST_BIT);
				stat.done = last_bit && (left_q == 16'd1);
			end
			default: stat = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q   <= DEFAULT_SEED;
			acc_q  <= '0;
			bit_q  <= '0;
			left_q <= '0;
		end else if (state_q == ST_IDLE) begin
			if (ctrl.start) begin
				case (ctrl.kind)
					KIND_NEXT: gs_q <= step_next;
					KIND_SEED: gs_q <= seed_zero ? DEFAULT_SEED : seed;
					KIND_JUMP: begin
						left_q <= ctrl.jump_count;
						bit_q  <= '0;
						acc_q  <= '0;
					end
					default: ;
				endcase
			end
		end else begin
			bit_q <= bit_q + 8'd1;
			if (last_bit) begin
				// The step after the last tap is discarded: the sum becomes the state.
				gs_q   <= acc_q ^ (poly_bit ? gs_q : '0);
				acc_q  <= '0;
				left_q <= left_q - 16'd1;
			end else begin
				gs_q <= step_next;
				if (poly_bit) begin
					acc_q <= acc_q ^ gs_q;
				end
			end
		end
	end
endmodule

// ===== rtl/xoshiro256pp_generator_unit.sv =====
// Channel | Dir | Payload                  | Transaction
// req     | in  | kind[1:0], jump_count    | req.valid & req.ready
// rsp     | out | value[63:0]              | rsp.valid & rsp.ready
// cfg     | in  | index[1:0], data[63:0]   | cfg.valid & cfg.ready (always ready)
// Next, seed, unused-kind and zero-count jump requests finish in the cycle
// they are taken; the result is registered and visible in the next cycle.
// A jump request runs jump_count jumps on the single state-step unit.
// Reset loads the default seed and clears the seed registers.
// A request is taken only while no jump is running and the result slot is free
// or is being read in the same cycle.
module xoshiro256pp_generator_unit (
	input  logic clk,
	input  logic arst_n,
	xsr_req_if.sink   req,
	xsr_rsp_if.source rsp,
	xsr_cfg_if.sink   cfg
);
	import xsr_pkg::*;
	`include "xoshiro256pp_generator_unit_macros.svh"

	words_t     seed_q;
	logic       out_valid_q;
	word_t      out_value_q;
	core_ctrl_t ctrl;
	core_stat_t stat;
	logic       slot_free;

	assign slot_free  = !out_valid_q || rsp.ready;
	assign req.ready  = !stat.busy && slot_free;
	assign cfg.ready  = 1'b1;

	assign ctrl.start      = req.valid && req.ready;
	assign ctrl.kind       = req.kind;
	assign ctrl.jump_count = req.jump_count;

	xsr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.seed   (seed_q),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			seed_q[cfg.index] <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			out_value_q <= stat.value;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.value = out_value_q;

	`XSR_ASSERT_SAME(a_busy_blocks_req, stat.busy, !req.ready, "request taken during a jump")
	`XSR_ASSERT_SAME(a_done_slot_free, stat.done, slot_free, "result overwrites an unread result")
	`XSR_ASSERT_SAME(a_jump_end_result, $fell(stat.busy), rsp.valid, "jump ended without result")
	`XSR_ASSERT_NEXT(a_start_jump_busy, ctrl.start && !stat.done, stat.busy, "jump did not start")
endmodule

// ===== test/xoshiro256pp_generator_unit_tb.sv =====
`timescale 1ns / 1ps

module xoshiro256pp_generator_unit_tb;
	import xsr_pkg::*;

	// The request field allows a fourth kind that the block must answer with zero.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [1:0] REG_SEED_WORD0 = 2'd0;
	localparam logic [1:0] REG_SEED_WORD1 = 2'd1;
	localparam logic [1:0] REG_SEED_WORD2 = 2'd2;
	localparam logic [1:0] REG_SEED_WORD3 = 2'd3;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_ITEMS = 500;

	logic clk = 1'b0;
	logic arst_n;

	xsr_req_if req_ch();
	xsr_rsp_if rsp_ch();
	xsr_cfg_if cfg_ch();

	xoshiro256pp_generator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	words_t model_words;
	words_t seed_words;
	word_t  expected_values[$];

	int error_count = 0;
	int cycle_count = 0;
	int stall_left = 0;
	int hold_count = 0;
	bit gaps_on = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: run exceeded %0d cycles", $time, LIMIT_CYCLES);
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic word_t rotl64(word_t v, int unsigned n);
		return (v << n) | (v >> (64 - n));
	endfunction

	function automatic void step_generator();
		word_t t;
		t = model_words[1] << 17;
		model_words[2] ^= model_words[0];
		model_words[3] ^= model_words[1];
		model_words[1] ^= model_words[2];
		model_words[0] ^= model_words[3];
		model_words[2] ^= t;
		model_words[3] = rotl64(model_words[3], 45);
	endfunction

	// Works out the result of one request and moves the generator state on.
	function automatic word_t predict_value(logic [1:0] kind, logic [15:0] count);
		words_t acc;
		word_t result;
		result = '0;
		case (kind)
			KIND_NEXT: begin
				result = rotl64(model_words[0] + model_words[3], 23) + model_words[0];
				step_generator();
			end
			KIND_SEED: begin
				if (seed_words == '0)
					model_words = DEFAULT_SEED;
				else
					model_words = seed_words;
			end
			KIND_JUMP: begin
				for (int j = 0; j < count; j++) begin
					acc = '0;
					for (int b = 0; b < 256; b++) begin
						if (JUMP_POLY[b])
							acc ^= model_words;
						step_generator();
					end
					model_words = acc;
				end
			end
			default: begin
			end
		endcase
		return result;
	endfunction

	// Result side: checks each transaction and draws the stall before the next one.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_values.size() == 0) begin
				$display("%0t: unexpected result: expected none, got %h", $time, rsp_ch.value);
				error_count++;
			end else begin
				if (rsp_ch.value !== expected_values[0]) begin
					$display("%0t: value mismatch: expected %h, got %h",
						$time, expected_values[0], rsp_ch.value);
					error_count++;
				end
				void'(expected_values.pop_front());
			end
			stall_left = gaps_on ? $urandom_range(0, 4) : 0;
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (hold_count > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_count--;
			end else if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Leaves valid high after the transaction so that back-to-back requests keep it up.
	task automatic send_request(input logic [1:0] kind, input logic [15:0] count);
		int gap;
		gap = gaps_on ? $urandom_range(0, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.jump_count <= count;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		expected_values.push_back(predict_value(kind, count));
	endtask

	task automatic end_requests();
		@(negedge clk);
		req_ch.valid <= 1'b0;
	endtask

	task automatic wait_for_results();
		while (expected_values.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_seed_reg(input logic [1:0] index, input word_t data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		seed_words[index] = data;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic write_seed_words(input words_t w);
		write_seed_reg(REG_SEED_WORD0, w[0]);
		write_seed_reg(REG_SEED_WORD1, w[1]);
		write_seed_reg(REG_SEED_WORD2, w[2]);
		write_seed_reg(REG_SEED_WORD3, w[3]);
	endtask

	function automatic word_t random_word();
		return {$urandom(), $urandom()};
	endfunction

	task automatic test_reset_seed();
		repeat (3) send_request(KIND_NEXT, 16'h0000);
		// The seed registers are still zero, so this falls back to the default seed.
		send_request(KIND_SEED, 16'hffff);
		repeat (2) send_request(KIND_NEXT, 16'hffff);
		end_requests();
		wait_for_results();
	endtask

	task automatic test_seed_extremes();
		write_seed_words({4{64'hffff_ffff_ffff_ffff}});
		send_request(KIND_SEED, 16'h0000);
		repeat (2) send_request(KIND_NEXT, 16'h5555);
		end_requests();
		wait_for_results();
		write_seed_words({64'h0, 64'h0, 64'h0, 64'h1});
		send_request(KIND_SEED, 16'haaaa);
		send_request(KIND_NEXT, 16'h0000);
		end_requests();
		wait_for_results();
	endtask

	task automatic test_jump_and_unused();
		send_request(KIND_JUMP, 16'h0000);
		send_request(KIND_NEXT, 16'h0000);
		send_request(KIND_JUMP, 16'h0001);
		send_request(KIND_NEXT, 16'h0000);
		send_request(KIND_JUMP, 16'h0003);
		send_request(KIND_NEXT, 16'h0000);
		send_request(KIND_UNUSED, 16'hffff);
		send_request(KIND_NEXT, 16'hffff);
		end_requests();
		wait_for_results();
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_count = 200;
		repeat (30) send_request(KIND_NEXT, 16'($urandom_range(0, 65535)));
		end_requests();
		// The sender waits here until every result is back before offering more.
		wait_for_results();
		repeat (20) send_request(KIND_NEXT, 16'($urandom_range(0, 65535)));
		send_request(KIND_JUMP, 16'h0002);
		repeat (10) send_request(KIND_NEXT, 16'($urandom_range(0, 65535)));
		end_requests();
		wait_for_results();
		gaps_on = 1'b1;
	endtask

	task automatic send_random_request();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 75)
			send_request(KIND_NEXT, 16'($urandom_range(0, 65535)));
		else if (pick < 85)
			send_request(KIND_SEED, 16'($urandom_range(0, 65535)));
		else if (pick < 93)
			send_request(KIND_JUMP, 16'($urandom_range(0, 3)));
		else
			send_request(KIND_UNUSED, 16'($urandom_range(0, 65535)));
	endtask

	task automatic test_random_traffic();
		words_t w;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: w = {random_word(), random_word(), random_word(), random_word()};
				1: w = '0;
				2: w = {4{64'hffff_ffff_ffff_ffff}};
				default: w = {64'h0, random_word(), 64'h0, random_word()};
			endcase
			write_seed_words(w);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// A stretch in the middle of each phase runs with no idling at all.
				gaps_on = !(n >= 200 && n < 300);
				send_random_request();
			end
			gaps_on = 1'b1;
			end_requests();
			wait_for_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_NEXT;
		req_ch.jump_count = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_SEED_WORD0;
		cfg_ch.data = '0;
		model_words = DEFAULT_SEED;
		seed_words = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_seed();
		test_seed_extremes();
		test_jump_and_unused();
		test_backpressure();
		test_random_traffic();

		wait_for_results();
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== xoshiro256pp_generator_unit.f =====
+incdir+rtl
rtl/xsr_pkg.sv
rtl/xsr_if.sv
rtl/xsr_step.sv
rtl/xsr_core.sv
rtl/xoshiro256pp_generator_unit.sv
test/xoshiro256pp_generator_unit_tb.sv
